[rtl/two_tone_chime_generator_defines.svh]
// Assertion macros shared by the chime generator modules
`ifndef TWO_TONE_CHIME_GENERATOR_DEFINES_SVH
`define TWO_TONE_CHIME_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define TTC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("chime assertion failed");
`define TTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chime assertion failed");
`else
`define TTC_ASSERT(label, prop)
`define TTC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/ttc_pkg.sv]
// Types, constants and sine table function of the chime generator
package ttc_pkg;

  localparam logic [23:0] ENV_ONE = 24'h800000;
  localparam logic [12:0] GAIN_CONST = 13'd7209;
  localparam logic [15:0] VOLUME_MAX = 16'd32768;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef enum logic [2:0] {
    REG_VOLUME        = 3'd0,
    REG_TONE_A_STEP   = 3'd1,
    REG_TONE_B_STEP   = 3'd2,
    REG_TONE_B_DELAY  = 3'd3,
    REG_ATTACK_LENGTH = 3'd4,
    REG_ATTACK_STEP   = 3'd5,
    REG_DECAY_FACTOR  = 3'd6,
    REG_CHIME_LENGTH  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] volume;
    logic [31:0] tone_a_step;
    logic [31:0] tone_b_step;
    logic [13:0] tone_b_delay;
    logic [13:0] attack_length;
    logic [23:0] attack_step;
    logic [23:0] decay_factor;
    logic [13:0] chime_length;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    volume:        16'd32768,
    tone_a_step:   32'd78741067,
    tone_b_step:   32'd118111601,
    tone_b_delay:  14'd2160,
    attack_length: 14'd576,
    attack_step:   24'd14564,
    decay_factor:  24'd16769528,
    chime_length:  14'd8640
  };

  typedef struct packed {
    logic        active;
    logic        last;
    logic        tone_b_on;
    logic [23:0] env;
  } ctl_t;

  function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x = (HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (bits + 1);
    term = x;
    sum = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'(TAYLOR_DIV[n - 1]);
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

[rtl/ttc_queue.sv]
// Two-entry word queue between the front and back parts
module ttc_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_pop;

  assign do_pop     = pop && (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/ttc_front.sv]
// Front part: takes start words, steps the chime state and queues sample work
`include "two_tone_chime_generator_defines.svh"

module ttc_front #(
  parameter int PHASE_BITS = 32,
  parameter int TAB_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ttc_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          start_req,
  input  logic                          q_full,
  output logic                          q_push,
  output ttc_pkg::ctl_t                 work_ctl,
  output logic [TAB_BITS+1:0]           work_phase_a,
  output logic [TAB_BITS+1:0]           work_phase_b
);
  import ttc_pkg::*;

  localparam int ADDR_W = TAB_BITS + 2;

  logic [13:0]           sample_index;
  logic [23:0]           envelope_level;
  logic [PHASE_BITS-1:0] phase_a;
  logic [PHASE_BITS-1:0] phase_b;
  logic [13:0]           sample_index_next;
  logic [23:0]           envelope_level_next;
  logic [PHASE_BITS-1:0] phase_a_next;
  logic [PHASE_BITS-1:0] phase_b_next;

  logic                  acc;
  logic [13:0]           idx_cur;
  logic [23:0]           env_cur;
  logic [PHASE_BITS-1:0] pa_cur;
  logic [PHASE_BITS-1:0] pb_cur;
  logic                  act;
  logic                  lst;
  logic [14:0]           n;
  logic [24:0]           env_sum;
  logic [47:0]           env_decay;
  logic [23:0]           env_upd;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign q_push   = acc;

  always_comb begin
    idx_cur = start_req ? 14'd0 : sample_index;
    env_cur = start_req ? ((cfg.attack_length == 14'd0) ? ENV_ONE : 24'd0) : envelope_level;
    pa_cur  = start_req ? '0 : phase_a;
    pb_cur  = start_req ? '0 : phase_b;
    act     = (idx_cur < cfg.chime_length);
    n       = {1'b0, idx_cur} + 15'd1;
    lst     = act && (n == {1'b0, cfg.chime_length});
  end

  always_comb begin
    env_sum   = {1'b0, env_cur} + {1'b0, cfg.attack_step};
    env_decay = env_cur * cfg.decay_factor;
    if (n < {1'b0, cfg.attack_length}) begin
      env_upd = (env_sum > {1'b0, ENV_ONE}) ? ENV_ONE : env_sum[23:0];
    end else if (n == {1'b0, cfg.attack_length}) begin
      env_upd = ENV_ONE;
    end else begin
      env_upd = env_decay[47:24];
    end
  end

  always_comb begin
    sample_index_next   = idx_cur;
    envelope_level_next = env_cur;
    phase_a_next        = pa_cur;
    phase_b_next        = pb_cur;
    if (act) begin
      sample_index_next   = n[13:0];
      envelope_level_next = env_upd;
      phase_a_next        = pa_cur + cfg.tone_a_step[PHASE_BITS-1:0];
      if (idx_cur >= cfg.tone_b_delay) begin
        phase_b_next = pb_cur + cfg.tone_b_step[PHASE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index   <= CFG_RST.chime_length;
      envelope_level <= 24'd0;
      phase_a        <= '0;
      phase_b        <= '0;
    end else if (acc) begin
      sample_index   <= sample_index_next;
      envelope_level <= envelope_level_next;
      phase_a        <= phase_a_next;
      phase_b        <= phase_b_next;
    end
  end

  always_comb begin
    work_ctl.active    = act;
    work_ctl.last      = lst;
    work_ctl.tone_b_on = (idx_cur > cfg.tone_b_delay);
    work_ctl.env       = env_cur;
    work_phase_a       = pa_cur[PHASE_BITS-1 -: ADDR_W];
    work_phase_b       = pb_cur[PHASE_BITS-1 -: ADDR_W];
  end

  `TTC_ASSERT(a_env_bounded, envelope_level <= ENV_ONE)
  `TTC_ASSERT_NEXT(a_restart_index, acc && start_req && (cfg.chime_length != 14'd0), sample_index == 14'd1)
  `TTC_ASSERT_NEXT(a_tone_b_waits, acc && act && (idx_cur < cfg.tone_b_delay), phase_b == $past(pb_cur))

endmodule

[rtl/ttc_back.sv]
// Back part: sine lookup, mixing, envelope and volume scaling pipeline
`include "two_tone_chime_generator_defines.svh"

module ttc_back #(
  parameter int TAB_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          volume,
  input  logic                 q_valid,
  input  ttc_pkg::ctl_t        q_ctl,
  input  logic [TAB_BITS+1:0]  q_phase_a,
  input  logic [TAB_BITS+1:0]  q_phase_b,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   sample,
  output logic                 active,
  output logic                 last
);
  import ttc_pkg::*;

  localparam int TAB_SIZE = 1 << TAB_BITS;
  localparam logic signed [16:0] WEIGHT_A = 17'sd23593;
  localparam logic signed [16:0] WEIGHT_B = 17'sd14746;

  logic [14:0] rom [TAB_SIZE];

  for (genvar k = 0; k < TAB_SIZE; k++) begin : g_rom
    assign rom[k] = sine_entry(k, TAB_BITS);
  end

  logic                adv;
  logic [TAB_BITS-1:0] addr_a;
  logic [TAB_BITS-1:0] addr_b;
  logic [15:0]         vol_c;
  logic [28:0]         gain_full;
  logic [27:0]         gain;

  logic                s1_valid;
  ctl_t                s1_ctl;
  logic                s1_neg_a;
  logic                s1_neg_b;
  logic [14:0]         s1_rom_a;
  logic [14:0]         s1_rom_b;
  logic signed [16:0]  sa;
  logic signed [16:0]  sb;

  logic                s2_valid;
  ctl_t                s2_ctl;
  logic signed [33:0]  s2_pa;
  logic signed [33:0]  s2_pb;
  logic signed [34:0]  mix;
  logic [34:0]         mix_abs;

  logic                s3_valid;
  ctl_t                s3_ctl;
  logic                s3_neg;
  logic [30:0]         s3_mag;
  logic [54:0]         env_prod;

  logic                s4_valid;
  logic                s4_active;
  logic                s4_last;
  logic                s4_neg;
  logic [31:0]         s4_scaled;
  logic [59:0]         vol_prod;
  logic [15:0]         mag16;
  logic [15:0]         res;

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_valid;

  assign addr_a = q_phase_a[TAB_BITS] ? ~q_phase_a[TAB_BITS-1:0] : q_phase_a[TAB_BITS-1:0];
  assign addr_b = q_phase_b[TAB_BITS] ? ~q_phase_b[TAB_BITS-1:0] : q_phase_b[TAB_BITS-1:0];

  assign vol_c     = (volume > VOLUME_MAX) ? VOLUME_MAX : volume;
  assign gain_full = vol_c * GAIN_CONST;

  always_ff @(posedge clk) begin
    gain <= gain_full[27:0];
  end

  always_comb begin
    sa = s1_neg_a ? -$signed({2'b00, s1_rom_a}) : $signed({2'b00, s1_rom_a});
    sb = s1_neg_b ? -$signed({2'b00, s1_rom_b}) : $signed({2'b00, s1_rom_b});
    if (!s1_ctl.tone_b_on) begin
      sb = 17'sd0;
    end
    mix      = {s2_pa[33], s2_pa} + {s2_pb[33], s2_pb};
    mix_abs  = mix[34] ? -mix : mix;
    env_prod = s3_mag * s3_ctl.env;
    vol_prod = s4_scaled * gain;
    mag16    = {1'b0, vol_prod[59:45]};
    res      = s4_neg ? -mag16 : mag16;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl    <= q_ctl;
      s1_neg_a  <= q_phase_a[TAB_BITS+1];
      s1_neg_b  <= q_phase_b[TAB_BITS+1];
      s1_rom_a  <= rom[addr_a];
      s1_rom_b  <= rom[addr_b];
      s2_ctl    <= s1_ctl;
      s2_pa     <= sa * WEIGHT_A;
      s2_pb     <= sb * WEIGHT_B;
      s3_ctl    <= s2_ctl;
      s3_neg    <= mix[34];
      s3_mag    <= mix_abs[30:0];
      s4_active <= s3_ctl.active;
      s4_last   <= s3_ctl.last;
      s4_neg    <= s3_neg;
      s4_scaled <= env_prod[54:23];
      sample    <= s4_active ? $signed(res) : 16'sd0;
      active    <= s4_active;
      last      <= s4_active && s4_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  `TTC_ASSERT(a_no_min_code, !out_valid || (sample != 16'sh8000))
  `TTC_ASSERT(a_last_needs_active, !(out_valid && last) || active)

endmodule

[rtl/two_tone_chime_generator.sv]
// Top level of the two-tone chime generator
// Every input word accepted yields one PCM sample word; the block sustains one word per
// clock while in_stall stays low. The front steps the phase accumulators, sample
// counter and envelope (including the 24x24 decay multiply) combinationally for each
// word, so that loop sets the rate. A sample appears once the queue is written at the
// accepting edge and the word has passed five register stages (sine ROM read, tone
// weighting, mix, envelope, volume), the last of which is the output register.
// A two-word queue decouples the front from output stalls. Configuration writes are
// registered and must only be made while no word is in flight.
module two_tone_chime_generator #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               start_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample,
  output logic               active,
  output logic               last
);
  import ttc_pkg::*;

  localparam int TAB_BITS = $clog2(SINE_TABLE_DEPTH + 1) - 1;
  localparam int ADDR_W   = TAB_BITS + 2;
  localparam int DATA_W   = $bits(ctl_t) + 2 * ADDR_W;

  cfg_t              cfg;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  ctl_t              work_ctl;
  logic [ADDR_W-1:0] work_phase_a;
  logic [ADDR_W-1:0] work_phase_b;
  logic [DATA_W-1:0] q_head;
  ctl_t              head_ctl;
  logic [ADDR_W-1:0] head_phase_a;
  logic [ADDR_W-1:0] head_phase_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_addr))
        REG_VOLUME:        cfg.volume        <= cfg_wdata[15:0];
        REG_TONE_A_STEP:   cfg.tone_a_step   <= cfg_wdata;
        REG_TONE_B_STEP:   cfg.tone_b_step   <= cfg_wdata;
        REG_TONE_B_DELAY:  cfg.tone_b_delay  <= cfg_wdata[13:0];
        REG_ATTACK_LENGTH: cfg.attack_length <= cfg_wdata[13:0];
        REG_ATTACK_STEP:   cfg.attack_step   <= cfg_wdata[23:0];
        REG_DECAY_FACTOR:  cfg.decay_factor  <= cfg_wdata[23:0];
        REG_CHIME_LENGTH:  cfg.chime_length  <= cfg_wdata[13:0];
        default:           cfg <= cfg;
      endcase
    end
  end

  ttc_front #(
    .PHASE_BITS (PHASE_BITS),
    .TAB_BITS   (TAB_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_req    (start_req),
    .q_full       (q_full),
    .q_push       (q_push),
    .work_ctl     (work_ctl),
    .work_phase_a (work_phase_a),
    .work_phase_b (work_phase_b)
  );

  ttc_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({work_ctl, work_phase_a, work_phase_b}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign {head_ctl, head_phase_a, head_phase_b} = q_head;

  ttc_back #(
    .TAB_BITS (TAB_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .volume    (cfg.volume),
    .q_valid   (q_valid),
    .q_ctl     (head_ctl),
    .q_phase_a (head_phase_a),
    .q_phase_b (head_phase_b),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .active    (active),
    .last      (last)
  );

endmodule

[tb/two_tone_chime_generator_tb.sv]
// Self-checking testbench for the two-tone chime generator: directed and random chimes
module two_tone_chime_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttc_pkg::*;

  localparam int TONE_A_WEIGHT = 23593;
  localparam int TONE_B_WEIGHT = 14746;
  localparam int SINE_ENTRIES  = 256;
  localparam int HOLD_CYCLES   = 250;

  typedef struct {
    logic [15:0] sample;
    logic        active;
    logic        last;
  } chime_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_addr = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               start_req = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sample;
  logic               active;
  logic               last;

  two_tone_chime_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_req (start_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .active    (active),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // chime state mirrored from the block
  cfg_t        chime_cfg;
  logic [13:0] chime_index;
  logic [23:0] chime_env;
  logic [31:0] phase_a;
  logic [31:0] phase_b;
  int          sine_rom [SINE_ENTRIES];

  chime_word_t pending_samples [$];

  bit idle_on = 1'b0;
  bit hold_off_req = 1'b0;
  int errors = 0;
  int words_sent = 0;
  int chimes_started = 0;
  int samples_checked = 0;
  int active_seen = 0;
  int last_seen = 0;
  int settings_loaded = 0;

  function automatic int taylor_sine(input int unsigned k);
    longint unsigned x, term, acc, v;
    x = HALF_PI_Q30 * 64'(2 * k + 1) / 64'(2 * SINE_ENTRIES);
    term = x;
    acc = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? 32767 : int'(v);
  endfunction

  function automatic int sine_at(input logic [31:0] p);
    logic [1:0] quad;
    logic [7:0] idx;
    int         v;
    quad = p[31:30];
    idx = p[29:22];
    if (quad[0]) begin
      idx = 8'(SINE_ENTRIES - 1) - idx;
    end
    v = sine_rom[idx];
    return quad[1] ? -v : v;
  endfunction

  task automatic advance_chime(input logic start, output chime_word_t w);
    logic [13:0]     i;
    logic [14:0]     n;
    logic [24:0]     env_sum;
    longint          mix;
    longint unsigned mag;
    longint unsigned gain;
    int              s_a;
    int              s_b;
    w.sample = '0;
    w.active = 1'b0;
    w.last = 1'b0;
    if (start) begin
      chime_index = '0;
      chime_env = (chime_cfg.attack_length == 0) ? ENV_ONE : 24'd0;
      phase_a = '0;
      phase_b = '0;
    end
    if (chime_index >= chime_cfg.chime_length) begin
      return;
    end
    i = chime_index;
    s_a = sine_at(phase_a);
    s_b = (i > chime_cfg.tone_b_delay) ? sine_at(phase_b) : 0;
    mix = longint'(s_a) * TONE_A_WEIGHT + longint'(s_b) * TONE_B_WEIGHT;
    mag = (mix < 0) ? -mix : mix;
    mag = (mag * chime_env) >> 23;
    gain = (chime_cfg.volume > VOLUME_MAX) ? VOLUME_MAX : chime_cfg.volume;
    gain = gain * GAIN_CONST;
    mag = (mag * gain) >> 45;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    w.sample = (mix < 0) ? -16'(mag) : 16'(mag);
    w.active = 1'b1;
    w.last = (15'(i) + 15'd1 == 15'(chime_cfg.chime_length));
    phase_a = phase_a + chime_cfg.tone_a_step;
    if (i >= chime_cfg.tone_b_delay) begin
      phase_b = phase_b + chime_cfg.tone_b_step;
    end
    n = 15'(i) + 15'd1;
    if (n < 15'(chime_cfg.attack_length)) begin
      env_sum = 25'(chime_env) + 25'(chime_cfg.attack_step);
      chime_env = (env_sum > 25'(ENV_ONE)) ? ENV_ONE : env_sum[23:0];
    end else if (n == 15'(chime_cfg.attack_length)) begin
      chime_env = ENV_ONE;
    end else begin
      chime_env = 24'((64'(chime_env) * 64'(chime_cfg.decay_factor)) >> 24);
    end
    chime_index = n[13:0];
  endtask

  always @(posedge clk) begin : predict_in
    chime_word_t w;
    if (!rst && in_valid && !in_stall) begin
      advance_chime(start_req, w);
      pending_samples.push_back(w);
    end
  end

  always @(posedge clk) begin : check_out
    chime_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected sample word: sample %0d active %0b last %0b", sample, active, last);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", $signed(want.sample), sample);
          errors++;
        end
        if (active !== want.active) begin
          $error("active: expected %0b, got %0b", want.active, active);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          errors++;
        end
        samples_checked++;
        if (want.active) begin
          active_seen++;
        end
        if (want.last) begin
          last_seen++;
        end
      end
    end
  end

  initial begin : output_side
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic start);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_req <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (start) begin
      chimes_started++;
    end
  endtask

  // drop valid and let every sample in flight come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_VOLUME:        chime_cfg.volume = val[15:0];
      REG_TONE_A_STEP:   chime_cfg.tone_a_step = val;
      REG_TONE_B_STEP:   chime_cfg.tone_b_step = val;
      REG_TONE_B_DELAY:  chime_cfg.tone_b_delay = val[13:0];
      REG_ATTACK_LENGTH: chime_cfg.attack_length = val[13:0];
      REG_ATTACK_STEP:   chime_cfg.attack_step = val[23:0];
      REG_DECAY_FACTOR:  chime_cfg.decay_factor = val[23:0];
      REG_CHIME_LENGTH:  chime_cfg.chime_length = val[13:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_setting(input cfg_t c);
    wait_idle();
    write_reg(REG_VOLUME, 32'(c.volume));
    write_reg(REG_TONE_A_STEP, c.tone_a_step);
    write_reg(REG_TONE_B_STEP, c.tone_b_step);
    write_reg(REG_TONE_B_DELAY, 32'(c.tone_b_delay));
    write_reg(REG_ATTACK_LENGTH, 32'(c.attack_length));
    write_reg(REG_ATTACK_STEP, 32'(c.attack_step));
    write_reg(REG_DECAY_FACTOR, 32'(c.decay_factor));
    write_reg(REG_CHIME_LENGTH, 32'(c.chime_length));
    cfg_wr_en <= 1'b0;
    settings_loaded++;
  endtask

  task automatic set_chime_length(input logic [13:0] len);
    wait_idle();
    write_reg(REG_CHIME_LENGTH, 32'(len));
    cfg_wr_en <= 1'b0;
  endtask

  function automatic cfg_t random_setting();
    cfg_t        c;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      c.chime_length = 14'd0;
    end else if (pick == 1) begin
      c.chime_length = 14'($urandom_range(100, 16383));
    end else begin
      c.chime_length = 14'($urandom_range(1, 48));
    end
    c.tone_b_delay = ($urandom_range(0, 9) == 0) ? 14'h3FFF
                                                 : 14'($urandom_range(0, c.chime_length));
    c.attack_length = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(0, 16383))
                                                  : 14'($urandom_range(0, c.chime_length));
    c.attack_step = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                    : 24'($urandom_range(0, 32'h800000) >> $urandom_range(0, 4));
    c.decay_factor = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                     : 24'hFFFFFF - 24'($urandom_range(0, 32'h0FFFFF));
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      c.volume = 16'($urandom);
    end else if (pick == 1) begin
      c.volume = VOLUME_MAX;
    end else begin
      c.volume = 16'($urandom_range(0, 32768));
    end
    c.tone_a_step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h0400_0000) : $urandom;
    c.tone_b_step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h0400_0000) : $urandom;
    return c;
  endfunction

  task automatic test_idle_after_reset();
    repeat (3) send_word(1'b0);
    send_word(1'b1);
    repeat (4) send_word(1'b0);
  endtask

  task automatic test_directed_cases();
    cfg_t c;
    c = '{volume: 16'd32768, tone_a_step: 32'h4000_0000, tone_b_step: 32'h1234_5678,
          tone_b_delay: 14'd2, attack_length: 14'd3, attack_step: 24'hFFFFFF,
          decay_factor: 24'hFFFFFF, chime_length: 14'd6};
    program_setting(c);
    send_word(1'b1);
    repeat (6) send_word(1'b0);
    c = '{volume: 16'hFFFF, tone_a_step: 32'hFFFF_FFFF, tone_b_step: 32'hFFFF_FFFF,
          tone_b_delay: 14'd0, attack_length: 14'd0, attack_step: 24'hFFFFFF,
          decay_factor: 24'd0, chime_length: 14'd4};
    program_setting(c);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    // zero length: start gives nothing active
    c.chime_length = 14'd0;
    program_setting(c);
    send_word(1'b1);
    c = '{volume: 16'd0, tone_a_step: 32'h0100_0000, tone_b_step: 32'h0080_0000,
          tone_b_delay: 14'h3FFF, attack_length: 14'h3FFF, attack_step: 24'h800000,
          decay_factor: 24'h800000, chime_length: 14'd3};
    program_setting(c);
    send_word(1'b1);
    send_word(1'b0);
  endtask

  task automatic test_length_change();
    cfg_t c;
    c = '{volume: 16'd30000, tone_a_step: 32'h0A00_0000, tone_b_step: 32'h0F00_0000,
          tone_b_delay: 14'd1, attack_length: 14'd2, attack_step: 24'h300000,
          decay_factor: 24'hF00000, chime_length: 14'd3};
    program_setting(c);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    // raise length above the idle index: resume
    set_chime_length(14'd6);
    repeat (3) send_word(1'b0);
    set_chime_length(14'h3FFF);
    send_word(1'b1);
    repeat (2) send_word(1'b0);
    // lower length below the running index: end at once
    set_chime_length(14'd1);
    send_word(1'b0);
    // restart in the middle of a chime
    set_chime_length(14'd8);
    send_word(1'b1);
    repeat (2) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
  endtask

  task automatic test_random_chimes();
    cfg_t c;
    int   run_len;
    bit   noisy;
    while (words_sent < 1150) begin
      idle_on = ($urandom_range(0, 3) != 0);
      c = random_setting();
      program_setting(c);
      noisy = ($urandom_range(0, 7) == 0);
      run_len = ((c.chime_length > 64) ? 64 : int'(c.chime_length)) + $urandom_range(0, 4);
      send_word(1'b1);
      repeat (run_len) begin
        send_word(noisy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 39) == 0));
      end
      if ($urandom_range(0, 5) == 0 && c.chime_length < 14'd16000) begin
        set_chime_length(c.chime_length + 14'($urandom_range(1, 8)));
        repeat (10) send_word(1'b0);
      end
    end
  endtask

  task automatic test_output_hold_off();
    cfg_t c;
    idle_on = 1'b0;
    c = random_setting();
    c.chime_length = 14'd40;
    program_setting(c);
    hold_off_req = 1'b1;
    send_word(1'b1);
    repeat (59) send_word(1'b0);
  endtask

  task automatic test_steady_stream();
    cfg_t c;
    idle_on = 1'b0;
    repeat (3) begin
      c = random_setting();
      c.chime_length = 14'($urandom_range(20, 48));
      program_setting(c);
      send_word(1'b1);
      repeat (49) send_word($urandom_range(0, 29) == 0);
    end
  endtask

  initial begin : main
    int guard;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      sine_rom[k] = taylor_sine(k);
    end
    chime_cfg = CFG_RST;
    chime_index = CFG_RST.chime_length;
    chime_env = '0;
    phase_a = '0;
    phase_b = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    test_idle_after_reset();
    test_directed_cases();
    test_length_change();
    test_random_chimes();
    test_output_hold_off();
    test_steady_stream();
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending_samples.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_samples.size() != 0) begin
      $error("%0d sample words never arrived", pending_samples.size());
      errors++;
    end
    repeat (20) @(posedge clk);
    $display("covered %0d start words over %0d register settings, %0d input words in all",
             chimes_started, settings_loaded, words_sent);
    $display("checked %0d samples: %0d sounding, %0d chime ends", samples_checked,
             active_seen, last_seen);
    if (errors == 0) begin
      $display("two_tone_chime_generator_tb: clean");
    end else begin
      $display("two_tone_chime_generator_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #6ms;
    $display("two_tone_chime_generator_tb: errors");
    $finish;
  end

endmodule
